// ===== rtl/hpe_pkg.sv =====
// types, codes and tables shared by the histogram percentile engine
`timescale 1ns / 1ps
package hpe_pkg;

	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_SNAP  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_NEG  = 2'd2;
	localparam logic [1:0] STAT_DIS  = 2'd3;

	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_LOG_MODE = 3'd1;
	localparam logic [2:0] REG_RANGE    = 3'd2;
	localparam logic [2:0] REG_SCALE    = 3'd3;
	localparam logic [2:0] REG_BINS     = 3'd4;

	localparam logic [15:0] LN2_Q16 = 16'd45426;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] sample;
		logic [16:0]        pctile;
	} req_t;

	typedef struct packed {
		logic [5:0] bin_index;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic               enable;
		logic               log_mode;
		logic signed [31:0] range_min;
		logic [31:0]        bin_scale;
		logic [6:0]         bins_in_use;
	} cfg_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CLEAR, S_SNAP, S_MAP, S_NORM, S_LN, S_LNSUM, S_MUL,
		S_BIN, S_RD, S_WR, S_SUM, S_HMUL, S_HADD, S_WALK, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLEAR, OP_SNAP, OP_MAP, OP_NORM, OP_LN, OP_LNSUM, OP_MUL,
		OP_BIN, OP_RD, OP_WR, OP_SUM, OP_HMUL, OP_HADD, OP_WALK
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load;
		logic   push;
	} ctl_t;

	typedef struct packed {
		logic norm_done;
		logic clear_last;
		logic snap_last;
		logic sum_neg;
		logic sum_last;
		logic walk_end;
	} dp_st_t;

	// ln(1 + k/16) in q.16
	function automatic logic [15:0] ln_tab(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd3973;
			5'd2:  v = 16'd7719;
			5'd3:  v = 16'd11262;
			5'd4:  v = 16'd14624;
			5'd5:  v = 16'd17821;
			5'd6:  v = 16'd20870;
			5'd7:  v = 16'd23783;
			5'd8:  v = 16'd26573;
			5'd9:  v = 16'd29248;
			5'd10: v = 16'd31818;
			5'd11: v = 16'd34292;
			5'd12: v = 16'd36675;
			5'd13: v = 16'd38975;
			5'd14: v = 16'd41196;
			5'd15: v = 16'd43346;
			5'd16: v = 16'd45426;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

endpackage

// ===== rtl/hpe_datapath.sv =====
// counter banks, bin mapping and percentile walk datapath
`timescale 1ns / 1ps
module hpe_datapath import hpe_pkg::*; #(
	parameter int NUM_BINS    = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  req_t   req,
	input  ctl_t   ctl,
	output dp_st_t dst,
	output rsp_t   rsp
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int NW = AW + 1;
	localparam logic [NW-1:0] LAST = NW'(NUM_BINS - 1);
	localparam logic [NW-1:0] DEPTH = NW'(NUM_BINS);

	logic [COUNT_WIDTH-1:0] cur_mem [NUM_BINS];
	logic [COUNT_WIDTH-1:0] base_mem [NUM_BINS];
	logic [COUNT_WIDTH-1:0] cur_rd_s1, base_rd_s1;

	logic [NW-1:0] n_eff, n_last, idx_q;
	logic          rd_vld_s1, issue;
	logic [AW-1:0] rd_idx_s1, bin_q, cur_ra;

	logic signed [31:0] sample_q;
	logic [16:0]        pct_q;
	logic [5:0]         res_bin_q;
	logic [1:0]         res_st_q;
	rsp_t               rsp_q;

	logic        xpos_q;
	logic [31:0] u_q;
	logic [32:0] m_q;
	logic [5:0]  e_q;
	logic [31:0] ip_q;
	logic [15:0] lo_q;
	logic [21:0] eln_q, ln_q;
	logic [63:0] prod_q;

	logic [63:0] total_q, a_q, b_q, h_q, hp1_q;
	logic [16:0] hp2_q;

	logic signed [32:0] x_w;
	logic [15:0]        t_lo, t_hi, t_diff;
	logic [31:0]        ipr;
	logic [31:0]        mul_opd;
	logic [64:0]        r65;
	logic [48:0]        raw;
	logic [AW-1:0]      bin_c;
	logic [16:0]        pc;
	logic [63:0]        hp1_w;
	logic [32:0]        hp2_w;
	logic [COUNT_WIDTH-1:0] d;
	logic [63:0]        d64, b_new;
	logic               neg, stop;
	logic [AW-1:0]      walk_bin;
	logic               cur_we, base_we;
	logic [AW-1:0]      cur_wa, base_wa;
	logic [COUNT_WIDTH-1:0] cur_wd, base_wd;

	always_comb begin
		if (cfg.bins_in_use < 7'd2) begin
			n_eff = NW'(2);
		end else if (32'(cfg.bins_in_use) > NUM_BINS) begin
			n_eff = DEPTH;
		end else begin
			n_eff = NW'(cfg.bins_in_use);
		end
		n_last = n_eff - NW'(1);
	end

	assign issue = ((ctl.op == OP_SNAP) && (idx_q < DEPTH)) ||
		(((ctl.op == OP_SUM) || (ctl.op == OP_WALK)) && (idx_q < n_eff));

	// mapping arithmetic
	assign x_w = 33'(sample_q) - 33'(cfg.range_min);
	assign t_lo = ln_tab({1'b0, m_q[31:28]});
	assign t_hi = ln_tab({1'b0, m_q[31:28]} + 5'd1);
	assign t_diff = t_hi - t_lo;
	assign ipr = ip_q + 32'h0000_8000;
	assign mul_opd = cfg.log_mode ? 32'(ln_q) : u_q;
	assign r65 = cfg.log_mode ? (65'(prod_q) + 65'h0_8000_0000) : (65'(prod_q) + 65'h0_0000_8000);
	assign raw = cfg.log_mode ? 49'(r65[64:32]) : r65[64:16];
	assign bin_c = !xpos_q ? '0 : ((raw >= 49'(n_eff)) ? n_last[AW-1:0] : raw[AW-1:0]);

	// query arithmetic
	assign pc = (pct_q > 17'd65536) ? 17'd65536 : pct_q;
	assign hp1_w = 64'(total_q[63:16]) * 64'(pc);
	assign hp2_w = 33'(total_q[15:0]) * 33'(pc);
	assign d = cur_rd_s1 - base_rd_s1;
	assign d64 = 64'(d);
	assign neg = cur_rd_s1 < base_rd_s1;
	assign b_new = sat_add(b_q, d64);
	assign stop = (a_q <= h_q) && (h_q <= b_new);
	assign walk_bin = rd_idx_s1 - AW'(1) + AW'(h_q == b_new);

	always_comb begin
		dst.norm_done  = m_q[32];
		dst.clear_last = (ctl.op == OP_CLEAR) && (idx_q == LAST);
		dst.snap_last  = (ctl.op == OP_SNAP) && rd_vld_s1 && ({1'b0, rd_idx_s1} == LAST);
		dst.sum_neg    = (ctl.op == OP_SUM) && rd_vld_s1 && neg;
		dst.sum_last   = (ctl.op == OP_SUM) && rd_vld_s1 && ({1'b0, rd_idx_s1} == n_last);
		dst.walk_end   = (ctl.op == OP_WALK) && rd_vld_s1 &&
			(stop || ({1'b0, rd_idx_s1} == n_last));
	end

	// memory port selection
	always_comb begin
		cur_ra  = (ctl.op == OP_RD) ? bin_q : idx_q[AW-1:0];
		cur_we  = 1'b0;
		cur_wa  = idx_q[AW-1:0];
		cur_wd  = '0;
		base_we = 1'b0;
		base_wa = idx_q[AW-1:0];
		base_wd = '0;
		case (ctl.op)
			OP_CLEAR: begin
				cur_we  = 1'b1;
				base_we = 1'b1;
			end
			OP_WR: begin
				cur_we = 1'b1;
				cur_wa = bin_q;
				cur_wd = (&cur_rd_s1) ? cur_rd_s1 : cur_rd_s1 + COUNT_WIDTH'(1);
			end
			OP_SNAP: begin
				base_we = rd_vld_s1;
				base_wa = rd_idx_s1;
				base_wd = cur_rd_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		cur_rd_s1 <= cur_mem[cur_ra];
	end

	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[base_wa] <= base_wd;
		end
		base_rd_s1 <= base_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (ctl.load || (ctl.op == OP_HMUL)) begin
				idx_q <= '0;
			end else if ((ctl.op == OP_CLEAR) || issue) begin
				idx_q <= idx_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (ctl.load) begin
			sample_q  <= req.sample;
			pct_q     <= req.pctile;
			res_bin_q <= '0;
			res_st_q  <= (((req.cmd == CMD_COUNT) || (req.cmd == CMD_QUERY)) && !cfg.enable) ?
				STAT_DIS : STAT_OK;
			total_q   <= '0;
			a_q       <= '0;
			b_q       <= '0;
		end
		if (ctl.push) begin
			rsp_q <= '{bin_index: res_bin_q, status: res_st_q};
		end
		case (ctl.op)
			OP_MAP: begin
				xpos_q <= !x_w[32] && (x_w != 33'sd0);
				u_q    <= x_w[31:0];
				m_q    <= 33'(x_w[31:0]) + 33'd1;
				e_q    <= 6'd32;
			end
			OP_NORM: begin
				// shift until the leading one sits at the top
				if (!m_q[32]) begin
					m_q <= m_q << 1;
					e_q <= e_q - 6'd1;
				end
			end
			OP_LN: begin
				ip_q  <= 32'(t_diff) * 32'(m_q[27:12]);
				lo_q  <= t_lo;
				eln_q <= 22'(e_q) * 22'(LN2_Q16);
			end
			OP_LNSUM: begin
				ln_q <= eln_q + 22'(lo_q) + 22'(ipr[31:16]);
			end
			OP_MUL: begin
				prod_q <= 64'(cfg.bin_scale) * 64'(mul_opd);
			end
			OP_BIN: begin
				bin_q     <= bin_c;
				res_bin_q <= 6'(bin_c);
			end
			OP_SUM: begin
				if (rd_vld_s1) begin
					total_q <= sat_add(total_q, d64);
					if (neg) begin
						res_st_q <= STAT_NEG;
					end
				end
			end
			OP_HMUL: begin
				hp1_q <= hp1_w;
				hp2_q <= hp2_w[32:16];
			end
			OP_HADD: begin
				h_q <= hp1_q + 64'(hp2_q);
			end
			OP_WALK: begin
				if (rd_vld_s1) begin
					if (stop) begin
						if ((total_q == 64'd0) || (rd_idx_s1 == '0) || (a_q >= b_new)) begin
							res_st_q <= STAT_NONE;
						end else begin
							res_st_q  <= STAT_OK;
							res_bin_q <= 6'(walk_bin);
						end
					end else begin
						a_q <= sat_add(a_q, d64);
						b_q <= b_new;
						if ({1'b0, rd_idx_s1} == n_last) begin
							res_st_q <= STAT_NONE;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/hpe_ctrl.sv =====
// command sequencer for the histogram percentile engine
`timescale 1ns / 1ps
module hpe_ctrl import hpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_cmd,
	input  logic       enable,
	input  logic       log_mode,
	input  dp_st_t     dst,
	input  logic       rsp_stall,
	output logic       req_stall,
	output logic       rsp_valid,
	output ctl_t       ctl
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = OP_NONE;
		ctl.load = 1'b0;
		ctl.push = 1'b0;
		case (state_q)
			S_INIT: begin
				ctl.op = OP_CLEAR;
				if (dst.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					case (req_cmd)
						CMD_COUNT: state_d = enable ? S_MAP : S_DONE;
						CMD_SNAP:  state_d = S_SNAP;
						CMD_CLEAR: state_d = S_CLEAR;
						default:   state_d = enable ? S_SUM : S_DONE;
					endcase
				end
			end
			S_CLEAR: begin
				ctl.op = OP_CLEAR;
				if (dst.clear_last) begin
					state_d = S_DONE;
				end
			end
			S_SNAP: begin
				ctl.op = OP_SNAP;
				if (dst.snap_last) begin
					state_d = S_DONE;
				end
			end
			S_MAP: begin
				ctl.op  = OP_MAP;
				state_d = log_mode ? S_NORM : S_MUL;
			end
			S_NORM: begin
				ctl.op = OP_NORM;
				if (dst.norm_done) begin
					state_d = S_LN;
				end
			end
			S_LN: begin
				ctl.op  = OP_LN;
				state_d = S_LNSUM;
			end
			S_LNSUM: begin
				ctl.op  = OP_LNSUM;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctl.op  = OP_MUL;
				state_d = S_BIN;
			end
			S_BIN: begin
				ctl.op  = OP_BIN;
				state_d = S_RD;
			end
			S_RD: begin
				ctl.op  = OP_RD;
				state_d = S_WR;
			end
			S_WR: begin
				ctl.op  = OP_WR;
				state_d = S_DONE;
			end
			S_SUM: begin
				ctl.op = OP_SUM;
				if (dst.sum_neg) begin
					state_d = S_DONE;
				end else if (dst.sum_last) begin
					state_d = S_HMUL;
				end
			end
			S_HMUL: begin
				ctl.op  = OP_HMUL;
				state_d = S_HADD;
			end
			S_HADD: begin
				ctl.op  = OP_HADD;
				state_d = S_WALK;
			end
			S_WALK: begin
				ctl.op = OP_WALK;
				if (dst.walk_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ctl.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/histogram_percentile_engine.sv =====
// top level: configuration registers, sequencer and datapath
//
// Items arrive on req (cmd, sample, pctile) under req_valid / req_stall and
// each gives exactly one item on rsp (bin_index, status) under rsp_valid /
// rsp_stall. One item is worked on at a time; req_stall is low only while
// the block is idle. Work per item, from accept to result register:
//   count, linear:  map, scale, bin, read and write of the current bank
//   count, log:     as linear, after a normalize of (offset + 1) that shifts
//                   out each leading zero, and a table log
//   snapshot:       one read of the current bank per bin
//   clear:          one write per bin, both banks at once
//   query:          two walks through the banks (sum, then percentile walk)
//   disabled count or query: straight to the result
// A finished result waits in the output register while rsp_stall is high; the
// next item is still accepted and runs up to its own result. After reset a
// clearing pass zeroes both banks while req_stall is high; configuration
// writes on cfg_we are taken at any time.
`timescale 1ns / 1ps
module histogram_percentile_engine import hpe_pkg::*; #(
	parameter int NUM_BINS    = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t   cfg_q;
	ctl_t   ctl;
	dp_st_t dst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= 1'b0;
			cfg_q.log_mode    <= 1'b0;
			cfg_q.range_min   <= 32'sd0;
			cfg_q.bin_scale   <= 32'd65536;
			cfg_q.bins_in_use <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:   cfg_q.enable      <= cfg_data[0];
				REG_LOG_MODE: cfg_q.log_mode    <= cfg_data[0];
				REG_RANGE:    cfg_q.range_min   <= cfg_data;
				REG_SCALE:    cfg_q.bin_scale   <= cfg_data;
				REG_BINS:     cfg_q.bins_in_use <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	hpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.enable    (cfg_q.enable),
		.log_mode  (cfg_q.log_mode),
		.dst       (dst),
		.rsp_stall (rsp_stall),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.ctl       (ctl)
	);

	hpe_datapath #(
		.NUM_BINS    (NUM_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.ctl    (ctl),
		.dst    (dst),
		.rsp    (rsp)
	);

endmodule

// ===== test/tb_top.sv =====
// testbench for the histogram percentile engine: queued items, predicted results, checked in order
`timescale 1ns / 1ps
module tb_top;
	import hpe_pkg::*;

	localparam int NBINS      = 64;
	localparam int LIMIT      = 3000000;
	localparam logic [63:0] CNT_TOP = 64'hFFFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_ENABLE;
	logic [31:0] cfg_data = '0;

	histogram_percentile_engine #(.NUM_BINS(NBINS), .COUNT_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic        m_enable = 1'b0;
	logic        m_log = 1'b0;
	logic [31:0] m_range = '0;
	logic [31:0] m_scale = 32'd65536;
	logic [6:0]  m_bins = 7'd64;
	logic [63:0] live_bank [NBINS];
	logic [63:0] base_bank [NBINS];
	logic [63:0] ln_q [17] = '{64'd0, 64'd3973, 64'd7719, 64'd11262, 64'd14624, 64'd17821,
		64'd20870, 64'd23783, 64'd26573, 64'd29248, 64'd31818, 64'd34292, 64'd36675,
		64'd38975, 64'd41196, 64'd43346, 64'd45426};

	req_t pending_items [$];
	rsp_t results_due [$];
	int   fail_n = 0;
	int   shown = 0;
	int   cycles = 0;
	bit   calm = 1'b0;

	initial begin
		for (int i = 0; i < NBINS; i++) begin
			live_bank[i] = '0;
			base_bank[i] = '0;
		end
	end

	function automatic int bins_eff();
		int n;
		n = int'(m_bins);
		if (n < 2) n = 2;
		if (n > NBINS) n = NBINS;
		return n;
	endfunction

	function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	// natural log in q8.16 via 17-entry table with interpolation
	function automatic logic [63:0] ln_fix(input logic [63:0] y);
		int e;
		int k;
		logic [63:0] fr, rem, lo, hi;
		e = 0;
		while (e < 32 && (y >> (e + 1)) != 0) e++;
		fr = (y << (32 - e)) & 64'hFFFF_FFFF;
		k = int'(fr[31:28]);
		rem = (fr >> 12) & 64'hFFFF;
		lo = ln_q[k];
		hi = ln_q[k + 1];
		return 64'(e) * 64'(LN2_Q16) + lo + (((hi - lo) * rem + 64'h8000) >> 16);
	endfunction

	function automatic logic [5:0] bin_of(input logic [31:0] s);
		logic signed [63:0] x;
		logic [63:0] u, b;
		int n;
		n = bins_eff();
		x = $signed({{32{s[31]}}, s}) - $signed({{32{m_range[31]}}, m_range});
		if (x <= 0) return 6'd0;
		u = x;
		if (m_log) b = (64'(m_scale) * ln_fix(u + 64'd1) + 64'h8000_0000) >> 32;
		else b = (64'(m_scale) * u + 64'h8000) >> 16;
		if (b >= 64'(n)) b = 64'(n - 1);
		return b[5:0];
	endfunction

	function automatic logic [1:0] pctile_walk(input logic [16:0] pct, output logic [5:0] bin);
		int n;
		logic [31:0] lo_i, hi_i, q;
		logic [63:0] tot, h, a, b, p, d;
		bit stop;
		n = bins_eff();
		lo_i = 0;
		hi_i = n;
		tot = 0;
		a = 0;
		b = 0;
		stop = 0;
		bin = 6'd0;
		for (int i = 0; i < n; i++) begin
			if (live_bank[i] < base_bank[i]) return STAT_NEG;
			tot = add_clip(tot, live_bank[i] - base_bank[i]);
		end
		p = (pct > 17'd65536) ? 64'd65536 : 64'(pct);
		h = (tot >> 16) * p + (((tot & 64'hFFFF) * p) >> 16);
		for (int i = 0; i < n && !stop; i++) begin
			d = live_bank[i] - base_bank[i];
			hi_i = i;
			b = add_clip(b, d);
			if (a <= h && h <= b) stop = 1;
			else begin
				lo_i = i;
				a = add_clip(a, d);
			end
		end
		if (tot == 0 || !stop || a > h || a >= b || lo_i >= hi_i) return STAT_NONE;
		q = 32'((h - a) / (b - a));
		bin = 6'(lo_i + q * (hi_i - lo_i));
		return STAT_OK;
	endfunction

	function automatic rsp_t histo_predict(input req_t it);
		rsp_t r;
		logic [5:0] bi;
		r.bin_index = 6'd0;
		r.status = STAT_OK;
		case (it.cmd)
			CMD_COUNT: begin
				if (!m_enable) r.status = STAT_DIS;
				else begin
					bi = bin_of(it.sample);
					r.bin_index = bi;
					if (live_bank[bi] < CNT_TOP) live_bank[bi] = live_bank[bi] + 64'd1;
				end
			end
			CMD_SNAP: begin
				for (int i = 0; i < NBINS; i++) base_bank[i] = live_bank[i];
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NBINS; i++) begin
					live_bank[i] = '0;
					base_bank[i] = '0;
				end
			end
			default: begin
				if (!m_enable) r.status = STAT_DIS;
				else begin
					r.status = pctile_walk(it.pctile, bi);
					r.bin_index = (r.status == STAT_OK) ? bi : 6'd0;
				end
			end
		endcase
		return r;
	endfunction

	// driver: predicts at accept, then loads the next pending item
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) results_due.push_back(histo_predict(req));
			if (!req_valid || !req_stall) begin
				if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (results_due.size() == 0) begin
				fail_n++;
				if (shown < 10) begin
					shown++;
					$display("unexpected item: bin %0d status %0d", rsp.bin_index, rsp.status);
				end
			end else begin
				want = results_due.pop_front();
				if (want.bin_index !== rsp.bin_index || want.status !== rsp.status) begin
					fail_n++;
					if (shown < 10) begin
						shown++;
						$display("mismatch: bin exp %0d got %0d, status exp %0d got %0d",
							want.bin_index, rsp.bin_index, want.status, rsp.status);
					end
				end
			end
		end
		rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENABLE:   m_enable = val[0];
			REG_LOG_MODE: m_log = val[0];
			REG_RANGE:    m_range = val;
			REG_SCALE:    m_scale = val;
			REG_BINS:     m_bins = val[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_item(input logic [1:0] c, input logic [31:0] s, input logic [16:0] p);
		req_t it;
		it.cmd = c;
		it.sample = s;
		it.pctile = p;
		pending_items.push_back(it);
	endtask

	// sender holds off until the block has answered everything
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() > 0 || req_valid || results_due.size() > 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_all(input logic en, input logic lg, input logic [31:0] rm,
			input logic [31:0] sc, input logic [6:0] nb);
		cfg_write(REG_ENABLE, {31'd0, en});
		cfg_write(REG_LOG_MODE, {31'd0, lg});
		cfg_write(REG_RANGE, rm);
		cfg_write(REG_SCALE, sc);
		cfg_write(REG_BINS, {25'd0, nb});
	endtask

	function automatic logic [31:0] pick_sample();
		logic [31:0] x;
		int r;
		r = $urandom_range(9);
		if (r == 0) return $urandom();
		if (r == 1) return m_range - $urandom_range(0, 1000);
		if (m_log) x = $urandom_range(0, (1 << $urandom_range(0, 31)) - 1);
		else if (m_scale == 0 || $urandom_range(7) == 0) x = $urandom();
		else x = $urandom_range(0, 32'((64'd80 << 16) / m_scale));
		return m_range + x;
	endfunction

	function automatic logic [16:0] pick_pct();
		case ($urandom_range(5))
			0: return 17'd65536;
			1: return 17'($urandom_range(0, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic random_items(input int cnt);
		int r;
		for (int i = 0; i < cnt; i++) begin
			r = $urandom_range(99);
			if (r < 68) add_item(CMD_COUNT, pick_sample(), 17'($urandom()));
			else if (r < 73) add_item(CMD_SNAP, $urandom(), 17'($urandom()));
			else if (r < 76) add_item(CMD_CLEAR, $urandom(), 17'($urandom()));
			else add_item(CMD_QUERY, $urandom(), pick_pct());
		end
	endtask

	initial begin
		logic [6:0]  nb;
		logic [31:0] sc, rm;
		logic        lg;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// disabled block: counts and queries are refused
		add_item(CMD_COUNT, 32'd5, 17'd0);
		add_item(CMD_QUERY, 32'd0, 17'd32768);
		add_item(CMD_SNAP, 32'd0, 17'd0);
		add_item(CMD_CLEAR, 32'd0, 17'd0);
		drain();

		set_all(1'b1, 1'b0, 32'd0, 32'd65536, 7'd64);
		add_item(CMD_QUERY, 32'd0, 17'd32768);
		add_item(CMD_COUNT, 32'd0, 17'd0);
		add_item(CMD_COUNT, 32'hFFFF_FFFF, 17'd0);
		add_item(CMD_COUNT, 32'd1, 17'd0);
		add_item(CMD_COUNT, 32'd5, 17'd0);
		add_item(CMD_COUNT, 32'd5, 17'd0);
		add_item(CMD_COUNT, 32'd63, 17'd0);
		add_item(CMD_COUNT, 32'd64, 17'd0);
		add_item(CMD_COUNT, 32'h7FFF_FFFF, 17'd0);
		add_item(CMD_COUNT, 32'h8000_0000, 17'd0);
		add_item(CMD_QUERY, 32'd0, 17'd0);
		add_item(CMD_QUERY, 32'd0, 17'd32768);
		add_item(CMD_QUERY, 32'd0, 17'd65536);
		add_item(CMD_QUERY, 32'd0, 17'd131071);
		add_item(CMD_SNAP, 32'd0, 17'd0);
		add_item(CMD_QUERY, 32'd0, 17'd32768);
		add_item(CMD_COUNT, 32'd3, 17'd0);
		add_item(CMD_QUERY, 32'd0, 17'd65535);
		add_item(CMD_CLEAR, 32'd0, 17'd0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			lg = 1'($urandom_range(1));
			rm = ($urandom_range(1) == 0) ? $urandom_range(0, 200) - 100 : $urandom();
			nb = 7'($urandom_range(2, 64));
			sc = lg ? $urandom_range(1 << 15, 4 << 16) : $urandom_range(1 << 12, 1 << 18);
			case (ph)
				0: begin nb = 7'd0; sc = 32'd0; end
				1: begin nb = 7'd127; sc = 32'hFFFF_FFFF; rm = 32'h8000_0000; end
				2: begin nb = 7'd2; rm = 32'h7FFF_FFFF; lg = 1'b1; end
				3: begin nb = 7'd1; rm = 32'h8000_0000; lg = 1'b1; sc = 32'hFFFF_FFFF; end
				4: nb = 7'd64;
				5: nb = 7'd65;
				default: ;
			endcase
			calm = (ph == 6);
			set_all(ph != 7, lg, rm, sc, nb);
			random_items((ph == 7) ? 40 : 125);
			drain();
		end
		calm = 1'b0;

		repeat (40) @(posedge clk);
		if (fail_n == 0 && results_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
